@@ design/cmdf_pkg.sv @@
// ----------------------------------------------------------------------------
// cmdf_pkg: shared types and constants of the cross mean denoise filter
// Sizes, field widths, register indexes and the records that move between
// the front end, the queue, the line store fetch and the result emitter.
// ----------------------------------------------------------------------------
package cmdf_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCNT_W = COL_W + 1;
  localparam int HCNT_W = ROW_W + 1;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int TAG_W  = 8;
  localparam int SIZE_W = 9;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 9'd256;

  // Stream packing
  localparam int IN_DATA_W  = 2 * PIX_W;
  localparam int OUT_DATA_W = PIX_W + 2 * TAG_W;

  // Cross sum and division by five (multiply by reciprocal, exact up to 5*255)
  localparam int CROSS_POINTS = 5;
  localparam int SUM_W        = $clog2(CROSS_POINTS * (2 ** PIX_W - 1) + 1);
  localparam int DIV5_SHIFT   = 18;
  localparam int DIV5_MUL_W   = 16;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL =
    DIV5_MUL_W'((2 ** DIV5_SHIFT) / CROSS_POINTS + 1);
  localparam int PROD_W = SUM_W + DIV5_MUL_W;

  // Line store: two row banks
  localparam int LS_DEPTH = 2 * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);

  // Queue between front end and fetch
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified pixel
  typedef struct packed {
    logic [PIX_W-1:0] px;        // noisy pixel
    logic [PIX_W-1:0] prev;      // noisy pixel before it
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             r_ge1;
    logic             r_ge2;
    logic             last_row;
    logic             c_ge1;
    logic             c_ge2;
    logic             c_last;
  } cmdf_item_t;

  // Pixel plus its neighbors fetched from the line store.
  // Rows: top = r-2, mid = r-1, bottom = r (current).
  typedef struct packed {
    cmdf_item_t       item;
    logic [PIX_W-1:0] mc;        // mid row, column c
    logic [PIX_W-1:0] tc;        // top row, column c
    logic [PIX_W-1:0] ml;        // mid row, column c-1
    logic [PIX_W-1:0] mr;        // mid row, column c+1
    logic [PIX_W-1:0] bl;        // bottom row, column c-2
  } cmdf_rec_t;

endpackage

@@ design/cmdf_front.sv @@
// ----------------------------------------------------------------------------
// cmdf_front: input acceptance and raster classification
// Holds the size registers and the raster position, forms the noisy pixel
// and tags each transaction with its position and border flags.
// ----------------------------------------------------------------------------
module cmdf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [cmdf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cmdf_pkg::SIZE_W-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cmdf_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             q_full,
  output logic                             q_push,
  output cmdf_pkg::cmdf_item_t             q_item
);

  logic [cmdf_pkg::SIZE_W-1:0]  width_r;
  logic [cmdf_pkg::SIZE_W-1:0]  height_r;
  logic [cmdf_pkg::ROW_W-1:0]   row_r;
  logic [cmdf_pkg::COL_W-1:0]   col_r;
  logic [cmdf_pkg::PIX_W-1:0]   prev_r;
  logic [cmdf_pkg::ROW_W-1:0]   row_nxt;
  logic [cmdf_pkg::COL_W-1:0]   col_nxt;

  logic [cmdf_pkg::WCNT_W-1:0]  w;
  logic [cmdf_pkg::HCNT_W-1:0]  h;
  logic [cmdf_pkg::WCNT_W-1:0]  cc;
  logic [cmdf_pkg::WCNT_W-1:0]  cc1;
  logic [cmdf_pkg::HCNT_W-1:0]  rr;
  logic [cmdf_pkg::HCNT_W-1:0]  rr1;
  logic [cmdf_pkg::PIX_W-1:0]   px;
  logic                         accept;

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cmdf_pkg::WIDTH_RESET;
      height_r <= cmdf_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        cmdf_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        cmdf_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, large values saturate
  always_comb begin
    if (width_r == '0) begin
      w = cmdf_pkg::WCNT_W'(1);
    end else if (32'(width_r) > cmdf_pkg::MAX_WIDTH) begin
      w = cmdf_pkg::WCNT_W'(cmdf_pkg::MAX_WIDTH);
    end else begin
      w = cmdf_pkg::WCNT_W'(width_r);
    end
    if (height_r == '0) begin
      h = cmdf_pkg::HCNT_W'(1);
    end else if (32'(height_r) > cmdf_pkg::MAX_HEIGHT) begin
      h = cmdf_pkg::HCNT_W'(cmdf_pkg::MAX_HEIGHT);
    end else begin
      h = cmdf_pkg::HCNT_W'(height_r);
    end
  end

  // Resolve the position of this pixel and the next one
  always_comb begin
    cc = {1'b0, col_r};
    rr = {1'b0, row_r};
    if (cc >= w) begin
      cc = '0;
      rr = rr + 1'b1;
    end
    if (rr >= h) begin
      rr = '0;
    end
    cc1 = cc + 1'b1;
    rr1 = rr + 1'b1;
    if (cc1 >= w) begin
      col_nxt = '0;
      row_nxt = (rr1 >= h) ? '0 : rr1[cmdf_pkg::ROW_W-1:0];
    end else begin
      col_nxt = cc1[cmdf_pkg::COL_W-1:0];
      row_nxt = rr[cmdf_pkg::ROW_W-1:0];
    end
  end

  assign px = in_tdata[cmdf_pkg::PIX_W-1:0] +
              in_tdata[cmdf_pkg::IN_DATA_W-1:cmdf_pkg::PIX_W];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign q_push    = accept;

  // Classified transaction
  always_comb begin
    q_item.px       = px;
    q_item.prev     = prev_r;
    q_item.row      = rr[cmdf_pkg::ROW_W-1:0];
    q_item.col      = cc[cmdf_pkg::COL_W-1:0];
    q_item.r_ge1    = (rr != '0);
    q_item.r_ge2    = (rr >= cmdf_pkg::HCNT_W'(2));
    q_item.last_row = (rr1 == h);
    q_item.c_ge1    = (cc != '0);
    q_item.c_ge2    = (cc >= cmdf_pkg::WCNT_W'(2));
    q_item.c_last   = (cc1 == w);
  end

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      prev_r <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      prev_r <= px;
    end
  end

endmodule

@@ design/cmdf_queue.sv @@
// ----------------------------------------------------------------------------
// cmdf_queue: short queue of classified pixels
// Decouples the front end from the line store fetch so each can stall alone.
// ----------------------------------------------------------------------------
module cmdf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  cmdf_pkg::cmdf_item_t  push_item,
  output logic                  full,
  input  logic                  pop,
  output cmdf_pkg::cmdf_item_t  pop_item,
  output logic                  empty
);

  cmdf_pkg::cmdf_item_t          slot_r [cmdf_pkg::QUEUE_DEPTH];
  logic [cmdf_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [cmdf_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [cmdf_pkg::QCNT_W-1:0]   count_r;
  logic                          do_push;
  logic                          do_pop;

  assign full     = (count_r == cmdf_pkg::QCNT_W'(cmdf_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slot_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == cmdf_pkg::QPTR_W'(cmdf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == cmdf_pkg::QPTR_W'(cmdf_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cmdf_pkg::QCNT_W'(cmdf_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ design/cmdf_fetch.sv @@
// ----------------------------------------------------------------------------
// cmdf_fetch: line store and neighbor fetch
// Two-bank line store with two registered read ports. Each pixel runs one to
// three read phases, is written at its last phase, and, if it has a result,
// leaves as a record carrying all neighbors its results need.
// ----------------------------------------------------------------------------
module cmdf_fetch (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmdf_pkg::cmdf_item_t  q_item,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  rec_valid,
  input  logic                  rec_ready,
  output cmdf_pkg::cmdf_rec_t   rec
);

  // Read phases
  localparam logic [1:0] PH_AB = 2'd0;   // mid centre, top centre
  localparam logic [1:0] PH_CD = 2'd1;   // mid left, mid right
  localparam logic [1:0] PH_E  = 2'd2;   // bottom left of left

  logic [cmdf_pkg::PIX_W-1:0]  ls_mem [cmdf_pkg::LS_DEPTH];

  logic                        iss_valid_r;
  cmdf_pkg::cmdf_item_t        iss_r;
  logic [1:0]                  ph_r;
  logic [1:0]                  ph_nxt;
  logic                        pend_valid_r;
  cmdf_pkg::cmdf_item_t        pend_r;
  logic [cmdf_pkg::PIX_W-1:0]  rd0_r;
  logic [cmdf_pkg::PIX_W-1:0]  rd1_r;
  logic [cmdf_pkg::PIX_W-1:0]  sv_mc_r;
  logic [cmdf_pkg::PIX_W-1:0]  sv_tc_r;
  logic [cmdf_pkg::PIX_W-1:0]  sv_ml_r;
  logic [cmdf_pkg::PIX_W-1:0]  sv_mr_r;
  logic                        rec_valid_r;
  cmdf_pkg::cmdf_rec_t         rec_r;
  cmdf_pkg::cmdf_rec_t         rec_nxt;

  logic                        en;
  logic                        at_last;
  logic                        load;
  logic                        pend_has;
  logic [1:0]                  iss_lp;
  logic                        bank;
  logic [cmdf_pkg::LS_AW-1:0]  addr0;
  logic [cmdf_pkg::LS_AW-1:0]  addr1;
  logic [cmdf_pkg::LS_AW-1:0]  waddr;
  logic [cmdf_pkg::COL_W-1:0]  col;

  function automatic logic [1:0] last_phase(input cmdf_pkg::cmdf_item_t it);
    logic [1:0] lp;
    if (it.last_row && it.c_ge2) begin
      lp = PH_E;
    end else if (it.r_ge1) begin
      lp = PH_CD;
    end else begin
      lp = PH_AB;
    end
    return lp;
  endfunction

  function automatic logic [cmdf_pkg::LS_AW-1:0] line_addr(
    input logic b, input logic [cmdf_pkg::COL_W-1:0] c);
    logic [cmdf_pkg::LS_AW-1:0] a;
    a = cmdf_pkg::LS_AW'(c);
    if (b) begin
      a = a + cmdf_pkg::LS_AW'(cmdf_pkg::MAX_WIDTH);
    end
    return a;
  endfunction

  assign iss_lp   = last_phase(iss_r);
  assign at_last  = iss_valid_r && (ph_r == iss_lp);
  assign pend_has = pend_r.r_ge1 || (pend_r.last_row && (pend_r.c_ge1 || pend_r.c_last));

  // Stall only while a finished record cannot leave
  assign en    = !(pend_valid_r && pend_has && rec_valid_r && !rec_ready);
  assign load  = en && (!iss_valid_r || at_last);
  assign q_pop = load && !q_empty;

  // Read addresses per phase; bank holds the current row
  assign bank  = iss_r.row[0];
  assign col   = iss_r.col;
  assign waddr = line_addr(bank, col);

  always_comb begin
    unique case (ph_r)
      PH_CD: begin
        addr0 = line_addr(!bank, col - 1'b1);
        addr1 = line_addr(!bank, col + 1'b1);
      end
      PH_E: begin
        addr0 = line_addr(bank, col - 2'd2);
        addr1 = addr0;
      end
      default: begin
        addr0 = line_addr(!bank, col);
        addr1 = line_addr(bank, col);
      end
    endcase
  end

  // Line store: read before write at the same edge
  always_ff @(posedge clk) begin
    if (en) begin
      rd0_r <= ls_mem[addr0];
      rd1_r <= ls_mem[addr1];
      if (at_last) begin
        ls_mem[waddr] <= iss_r.px;
      end
    end
  end

  // Phase sequencer
  always_comb begin
    ph_nxt = ph_r;
    if (iss_valid_r) begin
      ph_nxt = at_last ? PH_AB : ph_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_valid_r  <= 1'b0;
      ph_r         <= PH_AB;
      pend_valid_r <= 1'b0;
    end else if (en) begin
      ph_r         <= ph_nxt;
      pend_valid_r <= at_last;
      if (load) begin
        iss_valid_r <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pend_r <= iss_r;
      if (q_pop) begin
        iss_r <= q_item;
      end
      // Hold data of earlier phases
      if (iss_valid_r && ph_r == PH_CD) begin
        sv_mc_r <= rd0_r;
        sv_tc_r <= rd1_r;
      end
      if (iss_valid_r && ph_r == PH_E) begin
        sv_ml_r <= rd0_r;
        sv_mr_r <= rd1_r;
      end
    end
  end

  // Assemble the record once the last read has returned
  always_comb begin
    rec_nxt.item = pend_r;
    rec_nxt.mc   = sv_mc_r;
    rec_nxt.tc   = sv_tc_r;
    rec_nxt.bl   = rd0_r;
    if (last_phase(pend_r) == PH_E) begin
      rec_nxt.ml = sv_ml_r;
      rec_nxt.mr = sv_mr_r;
    end else begin
      rec_nxt.ml = rd0_r;
      rec_nxt.mr = rd1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
    end else if (en && pend_valid_r && pend_has) begin
      rec_valid_r <= 1'b1;
    end else if (rec_ready) begin
      rec_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && pend_valid_r && pend_has) begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_valid_r |-> ph_r <= iss_lp)
    else $error("read phase beyond last phase of pixel");

  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !iss_valid_r |-> ph_r == PH_AB)
    else $error("phase counter moved without a pixel");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> pend_valid_r && rec_valid_r)
    else $error("fetch stalled with a free record slot");

endmodule

@@ design/cmdf_emit.sv @@
// ----------------------------------------------------------------------------
// cmdf_emit: cross sums and result output
// Walks the up to three results of a record, forms each five-point sum in
// one stage and divides by five into the output register in the next.
// ----------------------------------------------------------------------------
module cmdf_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rec_valid,
  output logic                              rec_ready,
  input  cmdf_pkg::cmdf_rec_t               rec,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cmdf_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);

  cmdf_pkg::cmdf_rec_t          e_r;
  logic                         e_valid_r;
  logic [2:0]                   mask_r;
  logic [2:0]                   sel;
  logic                         sel_last;

  logic                         s_valid_r;
  logic [cmdf_pkg::SUM_W-1:0]   s_sum_r;
  logic [cmdf_pkg::TAG_W-1:0]   s_row_r;
  logic [cmdf_pkg::TAG_W-1:0]   s_col_r;
  logic                         s_last_r;

  logic                         o_valid_r;
  logic [cmdf_pkg::PIX_W-1:0]   o_value_r;
  logic [cmdf_pkg::TAG_W-1:0]   o_row_r;
  logic [cmdf_pkg::TAG_W-1:0]   o_col_r;
  logic                         o_last_r;

  logic                         o_can;
  logic                         s_can;
  logic                         issue;
  logic                         take;
  logic [cmdf_pkg::PIX_W-1:0]   op_ctr;
  logic [cmdf_pkg::PIX_W-1:0]   op_up;
  logic [cmdf_pkg::PIX_W-1:0]   op_dn;
  logic [cmdf_pkg::PIX_W-1:0]   op_lf;
  logic [cmdf_pkg::PIX_W-1:0]   op_rt;
  logic [cmdf_pkg::ROW_W-1:0]   res_row;
  logic [cmdf_pkg::COL_W-1:0]   res_col;
  logic [cmdf_pkg::SUM_W-1:0]   sum;
  logic [cmdf_pkg::PROD_W-1:0]  prod;

  // Lowest pending result goes next
  assign sel      = mask_r & (~mask_r + 1'b1);
  assign sel_last = ((mask_r & ~sel) == '0);

  assign o_can     = !o_valid_r || out_tready;
  assign s_can     = !s_valid_r || o_can;
  assign issue     = e_valid_r && s_can;
  assign rec_ready = !e_valid_r || (issue && sel_last);
  assign take      = rec_valid && rec_ready;

  // Hold the record while its results go out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      mask_r    <= '0;
    end else if (take) begin
      e_valid_r <= 1'b1;
      mask_r    <= {rec.item.last_row && rec.item.c_last,
                    rec.item.last_row && rec.item.c_ge1,
                    rec.item.r_ge1};
    end else if (issue) begin
      mask_r <= mask_r & ~sel;
      if (sel_last) begin
        e_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      e_r <= rec;
    end
  end

  // Pick the five operands and the centre position of the selected result
  always_comb begin
    op_dn   = e_r.item.px;
    op_ctr  = e_r.mc;
    op_up   = e_r.item.r_ge2 ? e_r.tc : e_r.mc;
    op_lf   = e_r.item.c_ge1 ? e_r.ml : e_r.mc;
    op_rt   = e_r.item.c_last ? e_r.mc : e_r.mr;
    res_row = e_r.item.row - 1'b1;
    res_col = e_r.item.col;
    priority if (sel[0]) begin
      // Centre one row up, below neighbor is the new pixel
    end else if (sel[1]) begin
      // Centre is the pixel to the left on the last row
      op_ctr  = e_r.item.prev;
      op_dn   = e_r.item.prev;
      op_up   = e_r.item.r_ge1 ? e_r.ml : e_r.item.prev;
      op_lf   = e_r.item.c_ge2 ? e_r.bl : e_r.item.prev;
      op_rt   = e_r.item.px;
      res_row = e_r.item.row;
      res_col = e_r.item.col - 1'b1;
    end else begin
      // Centre is the last pixel of the last row
      op_ctr  = e_r.item.px;
      op_dn   = e_r.item.px;
      op_rt   = e_r.item.px;
      op_up   = e_r.item.r_ge1 ? e_r.mc : e_r.item.px;
      op_lf   = e_r.item.c_ge1 ? e_r.item.prev : e_r.item.px;
      res_row = e_r.item.row;
      res_col = e_r.item.col;
    end
  end

  assign sum = cmdf_pkg::SUM_W'(op_ctr) + cmdf_pkg::SUM_W'(op_up) +
               cmdf_pkg::SUM_W'(op_dn) + cmdf_pkg::SUM_W'(op_lf) +
               cmdf_pkg::SUM_W'(op_rt);

  // Sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (s_can) begin
      s_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s_sum_r  <= sum;
      s_row_r  <= cmdf_pkg::TAG_W'(res_row);
      s_col_r  <= cmdf_pkg::TAG_W'(res_col);
      s_last_r <= sel_last;
    end
  end

  // Divide by five through the reciprocal
  assign prod = cmdf_pkg::PROD_W'(s_sum_r) * cmdf_pkg::PROD_W'(cmdf_pkg::DIV5_MUL);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_can) begin
      o_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_can && s_valid_r) begin
      o_value_r <= cmdf_pkg::PIX_W'(prod >> cmdf_pkg::DIV5_SHIFT);
      o_row_r   <= s_row_r;
      o_col_r   <= s_col_r;
      o_last_r  <= s_last_r;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {o_col_r, o_row_r, o_value_r};
  assign out_tlast  = o_last_r;

  a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    e_valid_r |-> mask_r != '0)
    else $error("held record has no pending result");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    e_valid_r |-> $onehot(sel))
    else $error("result select not one-hot");

endmodule

@@ design/cross_mean_denoise_filter.sv @@
// ----------------------------------------------------------------------------
// cross_mean_denoise_filter: five-point cross mean over a noisy pixel stream
// Adds the noise byte to each raster pixel, keeps two rows in a line store
// and emits the floor of the mean of each pixel and its four neighbors,
// edges clamped, tagged with row and column.
//
// Channel   Dir   Handshake          Payload
// in_       in    tvalid/tready      tdata = pixel_value, noise_value
// out_      out   tvalid/tready      tdata = filtered_value, out_row, out_col;
//                                    tlast = last_of_run
// cfg_      in    wr_en              addr 0 = image_width, 1 = image_height
//
// The front end takes one pixel per cycle, while the queue has room, into a
// four-entry queue. The line store fetch reads mid and top centre on its two ports,
// below the first row also mid left and right, and on the last row from column 2
// also the bottom row at c-2; results leave at one per cycle while out_tready holds.
// Reset (synchronous, rst_n low) clears position, queue and pipeline and sets
// both sizes to 256; the line store is not cleared.
// Either channel may stall at any time; the queue and the output register
// let the input keep flowing while a result waits.
// ----------------------------------------------------------------------------
module cross_mean_denoise_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [cmdf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cmdf_pkg::SIZE_W-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cmdf_pkg::IN_DATA_W-1:0]   in_tdata,   // pixel_value, noise_value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cmdf_pkg::OUT_DATA_W-1:0]  out_tdata,  // filtered_value, out_row, out_col
  output logic                             out_tlast
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_empty;
  cmdf_pkg::cmdf_item_t  q_in_item;
  cmdf_pkg::cmdf_item_t  q_out_item;
  logic                  rec_valid;
  logic                  rec_ready;
  cmdf_pkg::cmdf_rec_t   rec;

  cmdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  cmdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty)
  );

  cmdf_fetch u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_out_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  cmdf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
